// ----- rtl/mck_pkg.sv -----
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, constants and the Morse pattern table for the keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int UNIT_W     = 10;
  localparam int DUR_W      = 12;
  localparam int CHAR_W     = 7;
  localparam int PAT_W      = 5;
  localparam int LEN_W      = 3;

  localparam logic [UNIT_W-1:0] UNIT_MS_RESET = 10'd50;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // keyer sequencing states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ON,
    ST_GAP,
    ST_LGAP,
    ST_WGAP
  } state_t;

  // segment length in units
  typedef enum logic [1:0] {
    UNITS_1,
    UNITS_2,
    UNITS_3,
    UNITS_4
  } units_t;

  // element pattern: bit i set means element i is a dash, len 0 means no entry
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] dashes;
  } pattern_t;

  // controller to datapath
  typedef struct packed {
    logic   load;
    logic   emit;
    logic   level;
    units_t units;
    logic   last;
    logic   shift;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_break;
    logic has_pat;
    logic in_word;
    logic elem_last;
    logic elem_dash;
    logic out_free;
  } status_t;

  // international morse lookup, letters and digits only
  function automatic pattern_t morse_lookup(input logic [CHAR_W-1:0] code);
    pattern_t p;
    p = '{len: 3'd0, dashes: 5'b00000};
    case (code)
      7'h41: p = '{len: 3'd2, dashes: 5'b00010}; // A .-
      7'h42: p = '{len: 3'd4, dashes: 5'b00001}; // B -...
      7'h43: p = '{len: 3'd4, dashes: 5'b00101}; // C -.-.
      7'h44: p = '{len: 3'd3, dashes: 5'b00001}; // D -..
      7'h45: p = '{len: 3'd1, dashes: 5'b00000}; // E .
      7'h46: p = '{len: 3'd4, dashes: 5'b00100}; // F ..-.
      7'h47: p = '{len: 3'd3, dashes: 5'b00011}; // G --.
      7'h48: p = '{len: 3'd4, dashes: 5'b00000}; // H ....
      7'h49: p = '{len: 3'd2, dashes: 5'b00000}; // I ..
      7'h4A: p = '{len: 3'd4, dashes: 5'b01110}; // J .---
      7'h4B: p = '{len: 3'd3, dashes: 5'b00101}; // K -.-
      7'h4C: p = '{len: 3'd4, dashes: 5'b00010}; // L .-..
      7'h4D: p = '{len: 3'd2, dashes: 5'b00011}; // M --
      7'h4E: p = '{len: 3'd2, dashes: 5'b00001}; // N -.
      7'h4F: p = '{len: 3'd3, dashes: 5'b00111}; // O ---
      7'h50: p = '{len: 3'd4, dashes: 5'b00110}; // P .--.
      7'h51: p = '{len: 3'd4, dashes: 5'b01011}; // Q --.-
      7'h52: p = '{len: 3'd3, dashes: 5'b00010}; // R .-.
      7'h53: p = '{len: 3'd3, dashes: 5'b00000}; // S ...
      7'h54: p = '{len: 3'd1, dashes: 5'b00001}; // T -
      7'h55: p = '{len: 3'd3, dashes: 5'b00100}; // U ..-
      7'h56: p = '{len: 3'd4, dashes: 5'b01000}; // V ...-
      7'h57: p = '{len: 3'd3, dashes: 5'b00110}; // W .--
      7'h58: p = '{len: 3'd4, dashes: 5'b01001}; // X -..-
      7'h59: p = '{len: 3'd4, dashes: 5'b01101}; // Y -.--
      7'h5A: p = '{len: 3'd4, dashes: 5'b00011}; // Z --..
      7'h30: p = '{len: 3'd5, dashes: 5'b11111}; // 0 -----
      7'h31: p = '{len: 3'd5, dashes: 5'b11110}; // 1 .----
      7'h32: p = '{len: 3'd5, dashes: 5'b11100}; // 2 ..---
      7'h33: p = '{len: 3'd5, dashes: 5'b11000}; // 3 ...--
      7'h34: p = '{len: 3'd5, dashes: 5'b10000}; // 4 ....-
      7'h35: p = '{len: 3'd5, dashes: 5'b00000}; // 5 .....
      7'h36: p = '{len: 3'd5, dashes: 5'b00001}; // 6 -....
      7'h37: p = '{len: 3'd5, dashes: 5'b00011}; // 7 --...
      7'h38: p = '{len: 3'd5, dashes: 5'b00111}; // 8 ---..
      7'h39: p = '{len: 3'd5, dashes: 5'b01111}; // 9 ----.
      default: p = '{len: 3'd0, dashes: 5'b00000};
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/morse_code_keyer.sv -----
// ----------------------------------------------------------------------------
// morse_code_keyer
// International Morse keyer: text characters in, keying segments out.
// ----------------------------------------------------------------------------
// One character is taken per transaction and turns into a run of
// (key_level, duration_ms) segments, the final one flagged by last_segment.
// A letter or digit gives a key on and a one unit key off per element, then a
// two unit letter gap; a space or end of text after a word gives a four unit
// word gap; anything else gives nothing. The sequencer drives one segment per
// cycle into the output register unless out_stall holds it full, and a character
// holds the input until its last segment has entered the output register.
// unit_ms resets to 50; the user writes it through cfg_wr_en / cfg_wr_data
// only while no character is in flight, as the block does not enforce this.
module morse_code_keyer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [mck_pkg::UNIT_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [mck_pkg::CHAR_W-1:0]  char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        key_level,
  output logic [mck_pkg::DUR_W-1:0]   duration_ms,
  output logic                        last_segment
);
  import mck_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  mck_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath and output register
  mck_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .kind         (kind),
    .char_code    (char_code),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .key_level    (key_level),
    .duration_ms  (duration_ms),
    .last_segment (last_segment)
  );

endmodule

// ----- rtl/mck_datapath.sv -----
// ----------------------------------------------------------------------------
// mck_datapath
// Unit register, word state, element shifter and the segment output register.
// ----------------------------------------------------------------------------
module mck_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [mck_pkg::UNIT_W-1:0]  cfg_wr_data,
  input  logic                        kind,
  input  logic [mck_pkg::CHAR_W-1:0]  char_code,
  input  logic                        out_stall,
  input  mck_pkg::cmd_t               cmd,
  output mck_pkg::status_t            status,
  output logic                        out_valid,
  output logic                        key_level,
  output logic [mck_pkg::DUR_W-1:0]   duration_ms,
  output logic                        last_segment
);
  import mck_pkg::*;

  logic [UNIT_W-1:0] unit_ms;
  logic              in_word;
  logic [PAT_W-1:0]  dashes;
  logic [LEN_W-1:0]  elem_left;
  pattern_t          pat;
  logic              is_break;
  logic [DUR_W-1:0]  unit_ext;
  logic [DUR_W-1:0]  dur_next;

  // input decode
  assign pat      = morse_lookup(char_code);
  assign is_break = (kind == KIND_END) || (char_code == CHAR_NUL) ||
                    (char_code == CHAR_SPACE);

  // unit length register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ms <= UNIT_MS_RESET;
    end else if (cfg_wr_en) begin
      unit_ms <= cfg_wr_data;
    end
  end

  // word tracking, updated when a transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      in_word <= 1'b0;
    end else if (cmd.load) begin
      in_word <= !is_break;
    end
  end

  // element shifter
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_left <= '0;
    end else if (cmd.load) begin
      elem_left <= pat.len;
    end else if (cmd.shift) begin
      elem_left <= elem_left - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dashes <= pat.dashes;
    end else if (cmd.shift) begin
      dashes <= {1'b0, dashes[PAT_W-1:1]};
    end
  end

  // segment length: unit times 1 to 4
  assign unit_ext = {{(DUR_W-UNIT_W){1'b0}}, unit_ms};
  always_comb begin
    case (cmd.units)
      UNITS_1: dur_next = unit_ext;
      UNITS_2: dur_next = unit_ext << 1;
      UNITS_3: dur_next = unit_ext + (unit_ext << 1);
      UNITS_4: dur_next = unit_ext << 2;
      default: dur_next = unit_ext;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      key_level    <= cmd.level;
      duration_ms  <= dur_next;
      last_segment <= cmd.last;
    end
  end

  // status to the controller
  assign status = '{
    is_break:  is_break,
    has_pat:   (pat.len != '0),
    in_word:   in_word,
    elem_last: (elem_left == LEN_W'(1)),
    elem_dash: dashes[0],
    out_free:  (!out_valid || !out_stall)
  };

endmodule

// ----- rtl/mck_ctrl.sv -----
// ----------------------------------------------------------------------------
// mck_ctrl
// Sequencer that walks one character through its key on and key off segments.
// ----------------------------------------------------------------------------
module mck_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mck_pkg::status_t  status,
  output mck_pkg::cmd_t     cmd
);
  import mck_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept   = in_valid && (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.is_break) begin
            state_next = status.in_word ? ST_WGAP : ST_IDLE;
          end else if (status.has_pat) begin
            state_next = ST_ON;
          end
        end
      end
      ST_ON: begin
        if (status.out_free) state_next = ST_GAP;
      end
      ST_GAP: begin
        if (status.out_free) state_next = status.elem_last ? ST_LGAP : ST_ON;
      end
      ST_LGAP: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_WGAP: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '{load: 1'b0, emit: 1'b0, level: 1'b0, units: UNITS_1,
            last: 1'b0, shift: 1'b0};
    case (state)
      ST_IDLE: begin
        cmd.load = accept;
      end
      ST_ON: begin
        cmd.emit  = status.out_free;
        cmd.level = 1'b1;
        cmd.units = status.elem_dash ? UNITS_3 : UNITS_1;
      end
      ST_GAP: begin
        cmd.emit  = status.out_free;
        cmd.units = UNITS_1;
        cmd.shift = status.out_free;
      end
      ST_LGAP: begin
        cmd.emit  = status.out_free;
        cmd.units = UNITS_2;
        cmd.last  = 1'b1;
      end
      ST_WGAP: begin
        cmd.emit  = status.out_free;
        cmd.units = UNITS_4;
        cmd.last  = 1'b1;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

endmodule
